[design/alm_pkg.sv]
// Package of shared codes and field widths for the array linked list manager.
package alm_pkg;

    localparam int KIND_W   = 3;
    localparam int KEY_IN_W = 32;
    localparam int SLOT_W   = 8;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Operation codes carried in the kind field; codes 5 to 7 are no-ops.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET        = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

endpackage

[design/alm_req_if.sv]
// Request channel interface of the array linked list manager.
interface alm_req_if;
    logic                          valid;
    logic                          ready;
    logic [alm_pkg::KIND_W-1:0]    kind;
    logic [alm_pkg::KEY_IN_W-1:0]  key_in;
    logic [alm_pkg::SLOT_W-1:0]    slot_in;
    logic [alm_pkg::POS_W-1:0]     position_in;

    modport source (output valid, kind, key_in, slot_in, position_in, input ready);
    modport sink   (input valid, kind, key_in, slot_in, position_in, output ready);
endinterface

[design/alm_rsp_if.sv]
// Response channel interface of the array linked list manager.
interface alm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [alm_pkg::SLOT_W-1:0]    slot_out;
    logic [alm_pkg::KEY_IN_W-1:0]  key_out;
    logic [alm_pkg::STATUS_W-1:0]  status;
    logic [alm_pkg::COUNT_W-1:0]   count_out;

    modport source (output valid, slot_out, key_out, status, count_out, input ready);
    modport sink   (input valid, slot_out, key_out, status, count_out, output ready);
endinterface

[design/array_linked_list_manager_top.sv]
// Top level of the array linked list manager: sequencer, slot memories and response register.
// A push passes the read, write, link and response states (an empty list skips link, a full
// one goes straight to response); a delete passes read, unlink, free and response (a free slot
// skips free, a bad slot goes to response at once); find and get repeat read and check per
// link followed, or go to response at once if refused. One transaction at a time, bounded by
// the single memory read port; the sequencer is ready as the result shows. A clearing pass
// over every slot after reset builds the free chain; requests wait. Reset is async, active low.
module array_linked_list_manager_top #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    alm_req_if.sink    req,
    alm_rsp_if.source  rsp
);

    // Slot index width, and a compare width that holds both the 8-bit fields and CAPACITY.
    localparam int SW = $clog2(CAPACITY);
    localparam int PW = ((SW > 8) ? SW : 8) + 1;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

    // The sequencer. Find and get share the walk states.
    typedef enum logic [10:0] {
        S_INIT       = 11'b000_0000_0001,
        S_IDLE       = 11'b000_0000_0010,
        S_PUSH_RD    = 11'b000_0000_0100,
        S_PUSH_WR    = 11'b000_0000_1000,
        S_PUSH_LINK  = 11'b000_0001_0000,
        S_DEL_RD     = 11'b000_0010_0000,
        S_DEL_UNLINK = 11'b000_0100_0000,
        S_DEL_FREE   = 11'b000_1000_0000,
        S_WALK_RD    = 11'b001_0000_0000,
        S_WALK_CHK   = 11'b010_0000_0000,
        S_RESP       = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // List pointers and the entry count. Slot 0 is the null link.
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [SW-1:0] free_reg, free_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW-1:0] init_idx_reg, init_idx_next;

    // The transaction being worked on.
    logic [alm_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [KEY_WIDTH-1:0]       key_reg, key_next;
    logic [SW-1:0]              slot_reg, slot_next;
    logic [alm_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [SW-1:0]              link_tgt_reg, link_tgt_next;
    logic [SW-1:0]              cur_reg, cur_next;
    logic [SW-1:0]              walk_idx_reg, walk_idx_next;
    logic [SW-1:0]              res_slot_reg, res_slot_next;
    logic [KEY_WIDTH-1:0]       res_key_reg, res_key_next;
    logic [alm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Response register, which frees the sequencer while a result waits.
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [alm_pkg::SLOT_W-1:0]    rsp_slot_reg, rsp_slot_next;
    logic [alm_pkg::KEY_IN_W-1:0]  rsp_key_reg, rsp_key_next;
    logic [alm_pkg::STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [alm_pkg::COUNT_W-1:0]   rsp_count_reg, rsp_count_next;

    // Slot memories. The link memory word is {in use, next link}; the key and previous-link
    // memories are only used for slots in use, so they need no clearing.
    logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
    logic [SW:0]          nxt_mem [CAPACITY];
    logic [SW-1:0]        prv_mem [CAPACITY];

    logic [KEY_WIDTH-1:0] key_rd_reg;
    logic [SW:0]          nxt_rd_reg;
    logic [SW-1:0]        prv_rd_reg;

    logic                 rd_en;
    logic [SW-1:0]        rd_addr;
    logic                 key_we, nxt_we, prv_we;
    logic [SW-1:0]        key_wa, nxt_wa, prv_wa;
    logic [KEY_WIDTH-1:0] key_wd;
    logic [SW:0]          nxt_wd;
    logic [SW-1:0]        prv_wd;

    logic                 accept;
    logic                 slot_ok;
    logic [SW-1:0]        walk_link;
    logic [SW-1:0]        walk_idx_inc;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.slot_out  = rsp_slot_reg;
    assign rsp.key_out   = rsp_key_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.count_out = rsp_count_reg;

    // A slot may be deleted only if it is a real slot; whether it is in use is read later.
    assign slot_ok = (req.slot_in != '0) && (PW'(req.slot_in) < CAP_P);

    assign walk_link    = nxt_rd_reg[SW-1:0];
    assign walk_idx_inc = SW'(walk_idx_reg + 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        init_idx_next   = init_idx_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        link_tgt_next   = link_tgt_reg;
        cur_next        = cur_reg;
        walk_idx_next   = walk_idx_reg;
        res_slot_next   = res_slot_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_slot_next   = rsp_slot_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        rd_en   = 1'b0;
        rd_addr = cur_reg;
        key_we  = 1'b0;
        key_wa  = slot_reg;
        key_wd  = key_reg;
        nxt_we  = 1'b0;
        nxt_wa  = slot_reg;
        nxt_wd  = '0;
        prv_we  = 1'b0;
        prv_wa  = slot_reg;
        prv_wd  = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Chain every slot to the next one; slot 0 and the last slot end in null.
                nxt_we = 1'b1;
                nxt_wa = init_idx_reg;
                if ((init_idx_reg == '0) || (init_idx_reg == LAST_SLOT))
                begin
                    nxt_wd = '0;
                end
                else
                begin
                    nxt_wd = {1'b0, SW'(init_idx_reg + 1'b1)};
                end
                init_idx_next = SW'(init_idx_reg + 1'b1);
                if (init_idx_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = req.kind;
                    key_next        = KEY_WIDTH'(req.key_in);
                    slot_next       = SW'(req.slot_in);
                    pos_next        = req.position_in;
                    cur_next        = head_reg;
                    walk_idx_next   = '0;
                    res_slot_next   = '0;
                    res_key_next    = '0;
                    res_status_next = alm_pkg::ST_OK;
                    state_next      = S_RESP;
                    unique case (req.kind) inside
                        alm_pkg::KIND_PUSH_FRONT, alm_pkg::KIND_PUSH_BACK:
                        begin
                            if (free_reg == '0)
                            begin
                                res_status_next = alm_pkg::ST_FULL;
                            end
                            else
                            begin
                                slot_next  = free_reg;
                                state_next = S_PUSH_RD;
                            end
                        end
                        alm_pkg::KIND_DELETE:
                        begin
                            if (!slot_ok)
                            begin
                                res_status_next = alm_pkg::ST_BAD_SLOT;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        alm_pkg::KIND_FIND:
                        begin
                            if ((count_reg == '0) || (head_reg == '0))
                            begin
                                res_status_next = alm_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        alm_pkg::KIND_GET:
                        begin
                            if ((PW'(req.position_in) >= PW'(count_reg)) || (head_reg == '0))
                            begin
                                res_status_next = alm_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_PUSH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_reg;
                state_next = S_PUSH_WR;
            end

            S_PUSH_WR:
            begin
                // The free chain moves on; the new slot is written with its key and links.
                free_next     = walk_link;
                count_next    = SW'(count_reg + 1'b1);
                res_slot_next = slot_reg;
                key_we        = 1'b1;
                nxt_we        = 1'b1;
                prv_we        = 1'b1;
                if (count_reg == '0)
                begin
                    nxt_wd     = {1'b1, {SW{1'b0}}};
                    prv_wd     = '0;
                    head_next  = slot_reg;
                    tail_next  = slot_reg;
                    state_next = S_RESP;
                end
                else if (kind_reg == alm_pkg::KIND_PUSH_FRONT)
                begin
                    nxt_wd        = {1'b1, head_reg};
                    prv_wd        = '0;
                    link_tgt_next = head_reg;
                    head_next     = slot_reg;
                    state_next    = S_PUSH_LINK;
                end
                else
                begin
                    nxt_wd        = {1'b1, {SW{1'b0}}};
                    prv_wd        = tail_reg;
                    link_tgt_next = tail_reg;
                    tail_next     = slot_reg;
                    state_next    = S_PUSH_LINK;
                end
            end

            S_PUSH_LINK:
            begin
                // Point the old head back, or the old tail forward, at the new slot.
                if (kind_reg == alm_pkg::KIND_PUSH_FRONT)
                begin
                    prv_we = 1'b1;
                    prv_wa = link_tgt_reg;
                    prv_wd = slot_reg;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = link_tgt_reg;
                    nxt_wd = {1'b1, slot_reg};
                end
                state_next = S_RESP;
            end

            S_DEL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_reg;
                state_next = S_DEL_UNLINK;
            end

            S_DEL_UNLINK:
            begin
                if (!nxt_rd_reg[SW])
                begin
                    res_status_next = alm_pkg::ST_BAD_SLOT;
                    state_next      = S_RESP;
                end
                else
                begin
                    res_key_next  = key_rd_reg;
                    res_slot_next = slot_reg;
                    if (prv_rd_reg != '0)
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd_reg;
                        nxt_wd = {1'b1, walk_link};
                    end
                    else
                    begin
                        head_next = walk_link;
                    end
                    if (walk_link != '0)
                    begin
                        prv_we = 1'b1;
                        prv_wa = walk_link;
                        prv_wd = prv_rd_reg;
                    end
                    else
                    begin
                        tail_next = prv_rd_reg;
                    end
                    state_next = S_DEL_FREE;
                end
            end

            S_DEL_FREE:
            begin
                // The freed slot goes to the front of the free chain.
                nxt_we     = 1'b1;
                nxt_wa     = slot_reg;
                nxt_wd     = {1'b0, free_reg};
                free_next  = slot_reg;
                count_next = SW'(count_reg - 1'b1);
                state_next = S_RESP;
            end

            S_WALK_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                state_next = S_RESP;
                if (kind_reg == alm_pkg::KIND_FIND)
                begin
                    if (key_rd_reg == key_reg)
                    begin
                        res_slot_next = cur_reg;
                    end
                    else if ((walk_idx_inc < count_reg) && (walk_link != '0))
                    begin
                        cur_next      = walk_link;
                        walk_idx_next = walk_idx_inc;
                        state_next    = S_WALK_RD;
                    end
                    else
                    begin
                        res_status_next = alm_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    if (PW'(walk_idx_reg) == PW'(pos_reg))
                    begin
                        res_slot_next = cur_reg;
                        res_key_next  = key_rd_reg;
                    end
                    else if (walk_link == '0)
                    begin
                        res_status_next = alm_pkg::ST_BAD_POS;
                    end
                    else
                    begin
                        cur_next      = walk_link;
                        walk_idx_next = walk_idx_inc;
                        state_next    = S_WALK_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_slot_next   = alm_pkg::SLOT_W'(res_slot_reg);
                    rsp_key_next    = alm_pkg::KEY_IN_W'(res_key_reg);
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = alm_pkg::COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= SW'(1);
            count_reg     <= '0;
            init_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            init_idx_reg  <= init_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        pos_reg        <= pos_next;
        link_tgt_reg   <= link_tgt_next;
        cur_reg        <= cur_next;
        walk_idx_reg   <= walk_idx_next;
        res_slot_reg   <= res_slot_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    // Slot memories: one write and one registered read per memory each cycle.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            nxt_rd_reg <= nxt_mem[rd_addr];
            prv_rd_reg <= prv_mem[rd_addr];
        end
    end

    // The free chain is empty exactly when the list holds CAPACITY-1 entries.
    a_free_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((free_reg == '0) == (count_reg == LAST_SLOT)))
        else $error("free chain and entry count disagree");

    // An empty list has a null head.
    a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((head_reg == '0) == (count_reg == '0)))
        else $error("head pointer and entry count disagree");

    // An empty list has a null tail.
    a_tail_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((tail_reg == '0) == (count_reg == '0)))
        else $error("tail pointer and entry count disagree");

    // A full status is only ever reported against a full list.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && (res_status_reg == alm_pkg::ST_FULL))
            |-> (count_reg == LAST_SLOT))
        else $error("full status reported with free slots left");

endmodule
